/* rtl/srt_pkg.sv */
// srt_pkg: item types and command, status and sort key codes
// of the sortable record table. No dependencies.
`default_nettype none
package srt_pkg;

	localparam int FIELD_BYTES = 20;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SORT   = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KEY_CANCEL = 2'd0,
		KEY_NAME   = 2'd1,
		KEY_TYPE   = 2'd2,
		KEY_AMOUNT = 2'd3
	} sort_key_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [63:0]        name_w0;
		logic [63:0]        name_w1;
		logic [31:0]        name_w2;
		logic [63:0]        type_w0;
		logic [63:0]        type_w1;
		logic [31:0]        type_w2;
		logic signed [31:0] amount;
		logic [1:0]         sort_key;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [4:0]         position;
		logic [4:0]         fill;
		logic [63:0]        out_name_w0;
		logic [63:0]        out_name_w1;
		logic [31:0]        out_name_w2;
		logic [63:0]        out_type_w0;
		logic [63:0]        out_type_w1;
		logic [31:0]        out_type_w2;
		logic signed [31:0] out_amount;
		logic               last;
	} out_item_t;

endpackage
`default_nettype wire

/* rtl/srt_cmp.sv */
// srt_cmp: shared record compare unit: ordering by the selected key
// and name equality. Uses srt_pkg.
`default_nettype none
module srt_cmp
	import srt_pkg::*;
#(
	parameter int TEXT_BYTES = 20
) (
	input  wire logic [1:0]                 key,
	input  wire logic [TEXT_BYTES*8*2+31:0] a,
	input  wire logic [TEXT_BYTES*8*2+31:0] b,
	output logic                            a_first,
	output logic                            names_eq
);
	localparam int TW = TEXT_BYTES * 8;

	logic [TW-1:0] a_name, b_name, a_type, b_type;
	logic signed [31:0] a_amt, b_amt;

	// text is zero filled past its end, so a plain unsigned compare is lexicographic
	assign {a_name, a_type, a_amt} = a;
	assign {b_name, b_type, b_amt} = b;
	assign names_eq = (a_name == b_name);

	always_comb begin
		case (key)
			KEY_NAME: a_first = (a_name < b_name);
			KEY_TYPE: a_first = (a_type < b_type);
			default:  a_first = (a_amt > b_amt);
		endcase
	end
endmodule
`default_nettype wire

/* rtl/sortable_record_table_core.sv */
// sortable_record_table_core: record table with add, remove, sort and list.
// Uses srt_pkg and srt_cmp.
//
// Channels: in_valid/in_ready/in_item take one command item; out_valid/
// out_ready/out_item deliver results; cfg_valid/cfg_ready/cfg_data write
// the capacity limit (always ready).
// Records live in a one-port-write, one-port-read memory with registered
// read; one shared compare unit serves remove and sort.
// Steps per command item:
//   add, and any command answered by status alone: one status item.
//   remove: a read and compare per record scanned, then a read and a
//   write per record shifted up. list: a read and an emit per record.
//   sort: insertion sort, per outer step a key read and then a read and
//   compare per position, ending with a placement; then the list.
// in_ready is high only while the sequencer is idle. When out_ready stays
// low the sequencer holds on the pending result; nothing is dropped.
// Reset clears the record count and sets the capacity limit to 10; the
// memory needs no clearing pass.
`default_nettype none
module sortable_record_table_core
	import srt_pkg::*;
#(
	parameter int MAX_RECORDS = 16,
	parameter int TEXT_BYTES  = 20
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [4:0] cfg_data
);
	localparam int TW = TEXT_BYTES * 8;
	localparam int RW = 2 * TW + 32;
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int LW = ((CW > 5) ? CW : 5) + 1;
	localparam int FW = FIELD_BYTES * 8;

	typedef enum logic [3:0] {
		S_IDLE, S_EMIT, S_RM_RD, S_RM_CMP, S_SH_RD, S_SH_WR,
		S_SO_RDI, S_SO_KEY, S_SO_RD, S_SO_CMP, S_SO_PUT, S_LS_RD, S_LS_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q, i_q, j_q;
	logic [4:0] cap_q;
	logic [2:0] status_q;
	logic [1:0] key_q;
	logic [TW-1:0] probe_q;
	logic [RW-1:0] keyrec_q, rdata_q;
	logic [RW-1:0] mem [MAX_RECORDS];
	logic out_valid_q;
	out_item_t out_q;

	logic rd_en, we;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [RW-1:0] wdata;
	logic [RW-1:0] cmp_a, cmp_b;
	logic a_first, names_eq;
	logic [TW-1:0] in_name, in_type;
	logic [FW-1:0] out_name, out_type;
	logic [LW-1:0] limit;
	logic accept, slot_free, is_last, emit;
	out_item_t plain_item;

	function automatic logic [TW-1:0] unpack_text(input logic [FW-1:0] f);
		logic [TW-1:0] t;
		logic ended;
		logic [7:0] b;
		t = '0;
		ended = 1'b0;
		for (int k = 0; k < TEXT_BYTES; k++) begin
			b = (k < FIELD_BYTES) ? f[FW-1-8*k -: 8] : 8'd0;
			if (b == 8'd0)
				ended = 1'b1;
			t[TW-1-8*k -: 8] = ended ? 8'd0 : b;
		end
		return t;
	endfunction

	function automatic logic [FW-1:0] pack_text(input logic [TW-1:0] t);
		logic [FW-1:0] f;
		f = '0;
		for (int k = 0; k < FIELD_BYTES; k++) begin
			if (k < TEXT_BYTES)
				f[FW-1-8*k -: 8] = t[TW-1-8*k -: 8];
		end
		return f;
	endfunction

	assign in_name = unpack_text({in_item.name_w0, in_item.name_w1, in_item.name_w2});
	assign in_type = unpack_text({in_item.type_w0, in_item.type_w1, in_item.type_w2});
	assign out_name = pack_text(rdata_q[RW-1 -: TW]);
	assign out_type = pack_text(rdata_q[RW-TW-1 -: TW]);

	assign limit = (LW'(cap_q) > LW'(MAX_RECORDS)) ? LW'(MAX_RECORDS) : LW'(cap_q);
	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign slot_free = !out_valid_q || out_ready;
	assign is_last = (i_q + 1'b1 == cnt_q);
	assign emit = ((state_q == S_EMIT) || (state_q == S_LS_OUT)) && slot_free;

	assign cmp_a = (state_q == S_SO_CMP) ? keyrec_q : rdata_q;
	assign cmp_b = (state_q == S_SO_CMP) ? rdata_q : {probe_q, {(TW+32){1'b0}}};

	srt_cmp #(.TEXT_BYTES(TEXT_BYTES)) u_cmp (
		.key(key_q), .a(cmp_a), .b(cmp_b), .a_first(a_first), .names_eq(names_eq)
	);

	always_comb begin
		plain_item = '0;
		plain_item.status = status_q;
		plain_item.fill = 5'(cnt_q);
		plain_item.last = 1'b1;
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = i_q[AW-1:0];
		we = 1'b0;
		wr_addr = i_q[AW-1:0];
		wdata = rdata_q;
		unique case (state_q)
			S_IDLE: begin
				we = accept && (in_item.cmd == CMD_ADD) && (LW'(cnt_q) < limit);
				wr_addr = cnt_q[AW-1:0];
				wdata = {in_name, in_type, in_item.amount};
			end
			S_RM_RD, S_LS_RD: rd_en = 1'b1;
			S_SO_RDI: rd_en = (i_q != cnt_q);
			S_SH_RD: begin
				rd_en = !is_last;
				rd_addr = AW'(i_q + 1'b1);
			end
			S_SH_WR: we = 1'b1;
			S_SO_RD: begin
				rd_en = 1'b1;
				rd_addr = AW'(j_q - 1'b1);
			end
			S_SO_CMP: begin
				we = a_first;
				wr_addr = j_q[AW-1:0];
			end
			S_SO_PUT: begin
				we = 1'b1;
				wr_addr = j_q[AW-1:0];
				wdata = keyrec_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wdata;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			cap_q <= 5'd10;
			status_q <= ST_OK;
			key_q <= KEY_CANCEL;
			probe_q <= '0;
			keyrec_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_valid)
				cap_q <= cfg_data;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= in_item.sort_key;
						probe_q <= in_name;
						i_q <= '0;
						state_q <= S_EMIT;
						case (in_item.cmd)
							CMD_ADD: begin
								if (LW'(cnt_q) < limit) begin
									cnt_q <= cnt_q + 1'b1;
									status_q <= ST_OK;
								end else
									status_q <= ST_FULL;
							end
							CMD_REMOVE: begin
								if (cnt_q == '0)
									status_q <= ST_EMPTY;
								else
									state_q <= S_RM_RD;
							end
							CMD_SORT: begin
								if (cnt_q == '0)
									status_q <= ST_EMPTY;
								else if (in_item.sort_key == KEY_CANCEL)
									status_q <= ST_CANCELLED;
								else begin
									i_q <= CW'(1);
									state_q <= S_SO_RDI;
								end
							end
							default: begin
								if (cnt_q == '0)
									status_q <= ST_EMPTY;
								else
									state_q <= S_LS_RD;
							end
						endcase
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_q <= plain_item;
						state_q <= S_IDLE;
					end
				end
				S_RM_RD: state_q <= S_RM_CMP;
				S_RM_CMP: begin
					if (names_eq)
						state_q <= S_SH_RD;
					else if (is_last) begin
						status_q <= ST_NOT_FOUND;
						state_q <= S_EMIT;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_RM_RD;
					end
				end
				S_SH_RD: begin
					if (is_last) begin
						cnt_q <= cnt_q - 1'b1;
						status_q <= ST_OK;
						state_q <= S_EMIT;
					end else
						state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					i_q <= i_q + 1'b1;
					state_q <= S_SH_RD;
				end
				S_SO_RDI: begin
					if (i_q == cnt_q) begin
						i_q <= '0;
						state_q <= S_LS_RD;
					end else
						state_q <= S_SO_KEY;
				end
				S_SO_KEY: begin
					keyrec_q <= rdata_q;
					j_q <= i_q;
					state_q <= S_SO_RD;
				end
				S_SO_RD: state_q <= S_SO_CMP;
				S_SO_CMP: begin
					if (a_first) begin
						j_q <= j_q - 1'b1;
						state_q <= (j_q == CW'(1)) ? S_SO_PUT : S_SO_RD;
					end else
						state_q <= S_SO_PUT;
				end
				S_SO_PUT: begin
					i_q <= i_q + 1'b1;
					state_q <= S_SO_RDI;
				end
				S_LS_RD: state_q <= S_LS_OUT;
				S_LS_OUT: begin
					if (slot_free) begin
						out_q.status <= ST_OK;
						out_q.position <= 5'(i_q + 1'b1);
						out_q.fill <= 5'(cnt_q);
						{out_q.out_name_w0, out_q.out_name_w1, out_q.out_name_w2} <= out_name;
						{out_q.out_type_w0, out_q.out_type_w1, out_q.out_type_w2} <= out_type;
						out_q.out_amount <= rdata_q[31:0];
						out_q.last <= is_last;
						if (is_last)
							state_q <= S_IDLE;
						else begin
							i_q <= i_q + 1'b1;
							state_q <= S_LS_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
